>>> rtl/core/rsmn_pkg.sv
package rsmn_pkg;

    // Field and register widths
    localparam int SAMPLE_W = 16;
    localparam int CC_W     = 7;
    localparam int NOTE_W   = 8;
    localparam int BEND_W   = 15;
    localparam int STICKY_W = 7;

    // Config port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Shared divider: signed dividend / signed divisor, two quotient bits per cycle
    localparam int DVD_W     = 32;
    localparam int DVS_W     = 18;
    localparam int DIV_BITS  = 2;
    localparam int DIV_ITERS = DVD_W / DIV_BITS;
    localparam int COUNT_W   = $clog2(DIV_ITERS);

    // Shared multiplier operand widths
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 15;

    // Bend range and reset values
    localparam int BEND_MIN   = -8192;
    localparam int BEND_MAX   = 8192;
    localparam int BEND_SLOPE = 8191;
    localparam logic [SAMPLE_W-1:0] CENTRE_RESET = 16'd400;
    localparam logic [STICKY_W-1:0] STICKY_RESET = 7'd10;

    typedef enum logic [2:0] {
        REG_INPUT_MIN  = 3'd0,
        REG_INPUT_MAX  = 3'd1,
        REG_THRESHOLD  = 3'd2,
        REG_CC_LOW     = 3'd3,
        REG_CC_HIGH    = 3'd4,
        REG_NOTE_LOW   = 3'd5,
        REG_NOTE_HIGH  = 3'd6,
        REG_STICKINESS = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_WAIT,
        S_DECIDE,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_CC,
        OP_NOTE,
        OP_STEP,
        OP_MARGIN,
        OP_MID,
        OP_BEND
    } op_t;

endpackage

>>> rtl/core/rsmn_div.sv
module rsmn_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rsmn_pkg::DVD_W-1:0]  dividend,
    input  logic signed [rsmn_pkg::DVS_W-1:0]  divisor,
    output logic                               done,
    output logic signed [rsmn_pkg::DVD_W-1:0]  quotient
);
    import rsmn_pkg::*;

    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [DVD_W-1:0]     q_reg;
    logic [DVS_W:0]       r_reg;
    logic [DVS_W-1:0]     d_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    logic signed [DVD_W-1:0] quot_reg;

    logic [DVD_W-1:0]     q_next;
    logic [DVS_W:0]       r_next;
    logic [DVS_W:0]       r_try;
    logic [DVD_W-1:0]     dvd_mag;
    logic [DVS_W-1:0]     dvs_mag;

    assign dvd_mag = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
    assign dvs_mag = divisor[DVS_W-1]  ? DVS_W'(-divisor)  : DVS_W'(divisor);

    // Restoring division, DIV_BITS steps per cycle on magnitudes
    always_comb
    begin
        r_next = r_reg;
        q_next = q_reg;
        r_try  = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r_try = {r_next[DVS_W-1:0], q_next[DVD_W-1]};
            if (r_try >= {1'b0, d_reg})
            begin
                r_next = r_try - {1'b0, d_reg};
                q_next = {q_next[DVD_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_try;
                q_next = {q_next[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            // last step runs on the count of zero
            fin_reg  <= busy_reg && !start && (count_reg == '0);
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= COUNT_W'(DIV_ITERS - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= dvd_mag;
            r_reg    <= '0;
            d_reg    <= dvs_mag;
            neg_reg  <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
        // truncating signed quotient; divide by zero gives zero
        if (fin_reg)
        begin
            priority if (zero_reg)
                quot_reg <= '0;
            else if (neg_reg)
                quot_reg <= -signed'(q_reg);
            else
                quot_reg <= signed'(q_reg);
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/core/ribbon_sensor_to_midi_note_top.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+--------------------------------------
// sample   | in_valid  / in_stall (out)  | sample[15:0]
// result   | out_valid / out_stall (in)  | cc_value[6:0], note[7:0] s, pitch_bend[14:0] s
// config   | APB psel/penable/pwrite     | paddr[4:2] register, pwdata, prdata
//
// One sample at a time. Each map is one pass through a shared 18x15 multiplier and, but for
// the hysteresis midpoint, a shared radix-4 divider. A released sample maps CC only; a
// touched one adds note and bend, and a note change under hysteresis test also maps step,
// margin and midpoint. in_stall is high from accept until the result transfer is loaded
// into the output register; a stalled result holds while the next sample runs.
// Reset (rst_n, async, active low) restores default calibration, note -1, bend 0, centre 400.
module ribbon_sensor_to_midi_note_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rsmn_pkg::ADDR_W-1:0]           paddr,
    input  logic [rsmn_pkg::DATA_W-1:0]           pwdata,
    output logic [rsmn_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rsmn_pkg::SAMPLE_W-1:0]         sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rsmn_pkg::CC_W-1:0]             cc_value,
    output logic signed [rsmn_pkg::NOTE_W-1:0]    note,
    output logic signed [rsmn_pkg::BEND_W-1:0]    pitch_bend
);
    import rsmn_pkg::*;

    // ---------------- configuration registers ----------------
    logic [SAMPLE_W-1:0] input_min_reg;
    logic [SAMPLE_W-1:0] input_max_reg;
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [CC_W-1:0]     cc_low_reg;
    logic [CC_W-1:0]     cc_high_reg;
    logic [CC_W-1:0]     note_low_reg;
    logic [CC_W-1:0]     note_high_reg;
    logic [STICKY_W-1:0] sticky_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_min_reg <= '0;
            input_max_reg <= '1;
            threshold_reg <= '0;
            cc_low_reg    <= '0;
            cc_high_reg   <= '1;
            note_low_reg  <= '0;
            note_high_reg <= '1;
            sticky_reg    <= STICKY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_INPUT_MIN:  input_min_reg <= pwdata[SAMPLE_W-1:0];
                REG_INPUT_MAX:  input_max_reg <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD:  threshold_reg <= pwdata[SAMPLE_W-1:0];
                REG_CC_LOW:     cc_low_reg    <= pwdata[CC_W-1:0];
                REG_CC_HIGH:    cc_high_reg   <= pwdata[CC_W-1:0];
                REG_NOTE_LOW:   note_low_reg  <= pwdata[CC_W-1:0];
                REG_NOTE_HIGH:  note_high_reg <= pwdata[CC_W-1:0];
                REG_STICKINESS: sticky_reg    <= pwdata[STICKY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_INPUT_MIN:  prdata = DATA_W'(input_min_reg);
            REG_INPUT_MAX:  prdata = DATA_W'(input_max_reg);
            REG_THRESHOLD:  prdata = DATA_W'(threshold_reg);
            REG_CC_LOW:     prdata = DATA_W'(cc_low_reg);
            REG_CC_HIGH:    prdata = DATA_W'(cc_high_reg);
            REG_NOTE_LOW:   prdata = DATA_W'(note_low_reg);
            REG_NOTE_HIGH:  prdata = DATA_W'(note_high_reg);
            REG_STICKINESS: prdata = DATA_W'(sticky_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic in_accept;
    logic out_free;
    logic out_load;
    logic div_start;
    logic div_done;
    logic signed [DVD_W-1:0] div_q;

    // ---------------- datapath state ----------------
    logic [SAMPLE_W-1:0]        c_reg;        // clamped sample
    logic signed [DVD_W-1:0]    prod_reg;
    logic [CC_W-1:0]            cc_reg;
    logic [CC_W-1:0]            nn_reg;       // candidate note
    logic signed [DVS_W-1:0]    step_reg;
    logic signed [DVS_W-1:0]    margin_reg;
    logic                       below_reg;    // sample at or below bend centre
    logic signed [NOTE_W-1:0]   note_reg;
    logic signed [BEND_W-1:0]   bend_reg;
    logic [SAMPLE_W-1:0]        centre_reg;

    logic                       out_valid_reg;
    logic [CC_W-1:0]            cc_out_reg;
    logic signed [NOTE_W-1:0]   note_out_reg;
    logic signed [BEND_W-1:0]   bend_out_reg;

    // ---------------- combinational helpers ----------------
    logic [SAMPLE_W-1:0]        clamp_c;
    logic signed [MUL_A_W-1:0]  c18, lo18, hi18, ctr18, ctr_eff18;
    logic signed [MUL_B_W-1:0]  ccl15, cch15, nl15, nh15, cur15;
    logic [SAMPLE_W-1:0]        ctr_eff;
    logic                       below_now;
    logic                       touched;
    logic [CC_W-1:0]            nn_now;
    logic                       hyst_now;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
    logic signed [DVS_W-1:0]    div_d;

    logic signed [DVS_W-1:0]    step_adj;
    logic signed [DVS_W-1:0]    half;
    logic signed [DVD_W-1:0]    half32, margin32, c32, mid32, up_th, dn_th;
    logic signed [DVD_W-1:0]    bend_full, bend_sat;

    always_comb
    begin
        priority if (sample < input_min_reg)
            clamp_c = input_min_reg;
        else if (sample > input_max_reg)
            clamp_c = input_max_reg;
        else
            clamp_c = sample;
    end

    assign c18   = signed'({2'b00, c_reg});
    assign lo18  = signed'({2'b00, input_min_reg});
    assign hi18  = signed'({2'b00, input_max_reg});
    assign ctr18 = signed'({2'b00, centre_reg});
    assign ccl15 = signed'({8'd0, cc_low_reg});
    assign cch15 = signed'({8'd0, cc_high_reg});
    assign nl15  = signed'({8'd0, note_low_reg});
    assign nh15  = signed'({8'd0, note_high_reg});
    assign cur15 = MUL_B_W'(note_reg);

    // a fresh centre is taken whenever the stored bend is zero
    assign ctr_eff   = (bend_reg == '0) ? c_reg : centre_reg;
    assign ctr_eff18 = signed'({2'b00, ctr_eff});
    assign below_now = (c_reg <= ctr_eff);
    assign touched   = (c_reg > threshold_reg);

    assign nn_now   = div_q[CC_W-1:0] + note_low_reg;
    assign hyst_now = (note_reg > 8'sd0) && (nn_now != note_reg[CC_W-1:0]);

    // shared multiplier operand select
    always_comb
    begin
        unique case (op_reg)
            OP_CC:
            begin
                mul_a = c18 - lo18;
                mul_b = cch15 - ccl15;
            end
            OP_NOTE:
            begin
                mul_a = c18 - lo18;
                mul_b = nh15 - nl15;
            end
            OP_STEP:
            begin
                mul_a = hi18 - lo18;
                mul_b = MUL_B_W'(1);
            end
            OP_MARGIN:
            begin
                mul_a = step_reg;
                mul_b = MUL_B_W'(1);
            end
            OP_MID:
            begin
                mul_a = step_reg;
                mul_b = cur15 - nl15;
            end
            OP_BEND:
            begin
                mul_a = c18 - ctr_eff18;
                mul_b = below_now ? MUL_B_W'(-BEND_SLOPE) : MUL_B_W'(BEND_SLOPE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divisor select
    always_comb
    begin
        unique case (op_reg)
            OP_CC, OP_NOTE: div_d = hi18 - lo18;
            OP_STEP:        div_d = signed'({3'b000, nh15}) - signed'({3'b000, nl15});
            OP_MARGIN:      div_d = signed'({11'd0, sticky_reg});
            OP_BEND:        div_d = below_reg ? (lo18 - ctr18) : (hi18 - ctr18);
            default:        div_d = '0;
        endcase
    end

    // hysteresis band edges: half rounds toward zero
    assign step_adj = step_reg + signed'({{(DVS_W-1){1'b0}}, step_reg[DVS_W-1]});
    assign half     = step_adj >>> 1;
    assign half32   = DVD_W'(half);
    assign margin32 = DVD_W'(margin_reg);
    assign c32      = signed'({16'd0, c_reg});
    assign mid32    = prod_reg + half32;
    assign up_th    = mid32 + (half32 + margin32);
    assign dn_th    = mid32 - (half32 + margin32);

    // bend offset and saturation
    assign bend_full = div_q + (below_reg ? -32'sd1 : 32'sd1);
    always_comb
    begin
        priority if (bend_full < BEND_MIN)
            bend_sat = BEND_MIN;
        else if (bend_full > BEND_MAX)
            bend_sat = BEND_MAX;
        else
            bend_sat = bend_full;
    end

    rsmn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                    op_next    = OP_CC;
                end
            end
            S_MUL:
            begin
                state_next = (op_reg == OP_MID) ? S_DECIDE : S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    unique case (op_reg)
                        OP_CC:
                        begin
                            state_next = touched ? S_MUL : S_FINISH;
                            op_next    = OP_NOTE;
                        end
                        OP_NOTE:
                        begin
                            state_next = S_MUL;
                            op_next    = hyst_now ? OP_STEP : OP_BEND;
                        end
                        OP_STEP:
                        begin
                            state_next = S_MUL;
                            op_next    = OP_MARGIN;
                        end
                        OP_MARGIN:
                        begin
                            state_next = S_MUL;
                            op_next    = OP_MID;
                        end
                        OP_BEND:
                        begin
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_DECIDE:
            begin
                state_next = S_MUL;
                op_next    = OP_BEND;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        div_start = (state_reg == S_LOAD);
        out_load  = (state_reg == S_FINISH) && out_free;
    end

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_CC;
            out_valid_reg <= 1'b0;
            note_reg      <= -8'sd1;
            bend_reg      <= '0;
            centre_reg    <= CENTRE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == S_MUL && op_reg == OP_BEND)
                centre_reg <= ctr_eff;

            if (div_done && op_reg == OP_CC && !touched)
            begin
                note_reg <= -8'sd1;
                bend_reg <= '0;
            end

            if (div_done && op_reg == OP_NOTE && !hyst_now)
                note_reg <= signed'({1'b0, nn_now});

            // note moves only once the sample clears the band plus margin
            if (state_reg == S_DECIDE)
            begin
                if (nn_reg > note_reg[CC_W-1:0])
                begin
                    if (c32 > up_th)
                        note_reg <= signed'({1'b0, nn_reg});
                end
                else if (c32 < dn_th)
                begin
                    note_reg <= signed'({1'b0, nn_reg});
                end
            end

            if (div_done && op_reg == OP_BEND)
                bend_reg <= BEND_W'(bend_sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            c_reg <= clamp_c;
        if (state_reg == S_MUL)
            prod_reg <= mul_p[DVD_W-1:0];
        if (state_reg == S_MUL && op_reg == OP_BEND)
            below_reg <= below_now;
        if (div_done)
        begin
            unique case (op_reg)
                OP_CC:     cc_reg     <= div_q[CC_W-1:0] + cc_low_reg;
                OP_NOTE:   nn_reg     <= nn_now;
                OP_STEP:   step_reg   <= div_q[DVS_W-1:0];
                OP_MARGIN: margin_reg <= div_q[DVS_W-1:0];
                default: ;
            endcase
        end
        if (out_load)
        begin
            cc_out_reg   <= cc_reg;
            note_out_reg <= note_reg;
            bend_out_reg <= bend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cc_value   = cc_out_reg;
    assign note       = note_out_reg;
    assign pitch_bend = bend_out_reg;

    // ---------------- assertions ----------------
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish state");

    a_release_no_bend: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && note == -8'sd1) |-> (pitch_bend == '0))
        else $error("released result carries a bend");

    a_bend_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pitch_bend >= -15'sd8192) && (pitch_bend <= 15'sd8192)))
        else $error("pitch bend out of range");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_WAIT))
        else $error("divider finished while sequencer not waiting");

endmodule
